/* rtl/core/gshc_pkg.sv */
`timescale 1ns / 1ps
package gshc_pkg;

    localparam int MAX_COUNT_DEF = 128;

    // Square of 256 * 10^0.8, scaled by 1024 and rounded.
    localparam logic [31:0] KSQ = 32'd2671651997;

    localparam logic [23:0] PPM_MAX = 24'hFFFFFF;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_HEAT_TICKS      = 3'd0;
    localparam logic [2:0] REG_WINDOW_TICKS    = 3'd1;
    localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd2;
    localparam logic [2:0] REG_ADC_FLOOR       = 3'd3;
    localparam logic [2:0] REG_FULL_SCALE      = 3'd4;
    localparam logic [2:0] REG_LOAD_RATIO      = 3'd5;

    localparam logic [19:0] HEAT_TICKS_RST      = 20'd60000;
    localparam logic [19:0] WINDOW_TICKS_RST    = 20'd90000;
    localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd1000;
    localparam logic [11:0] ADC_FLOOR_RST       = 12'd124;
    localparam logic [11:0] FULL_SCALE_RST      = 12'd4095;
    localparam logic [15:0] LOAD_RATIO_RST      = 16'd256;

    typedef struct packed {
        logic start;
        logic avg;      // 1: divide sum by count, 0: convert a code to ppm
    } calc_cmd_t;

    typedef struct packed {
        logic        done;
        logic [23:0] value;
    } calc_rsp_t;

endpackage

/* rtl/core/gas_sensor_heat_sample_cycle.sv */
`timescale 1ns / 1ps
// Gas sensor heater cycle. Each request on the s_ side is one millisecond tick
// with the sensor ADC code; each tick gives exactly one request on the m_ side
// with the heater drive, a sample flag, a cycle-done flag and the held average
// concentration (unsigned 16.8 ppm). The block heats for heat_ticks, then
// samples for window_ticks, converting at most one code per sample_interval
// ticks (up to MAX_COUNT per window), and at window end averages the sum.
// A tick that takes no sample and closes no window goes straight to the
// output register. A converted sample runs through the serial arithmetic
// unit: six 32-step shift-add multiplies, an 82-step restoring divide and a
// 24-step square root. Closing a window adds the divide of the sum by the
// count in that same unit. Configuration is to be written by the user
// through cfg_wr_en/cfg_addr/cfg_wr_data only while idle; not enforced here.
module gas_sensor_heat_sample_cycle #(
    parameter int MAX_COUNT = gshc_pkg::MAX_COUNT_DEF   // 1 to 255
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [11:0] adc_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // [0] heater_on, [1] sample_taken,
                                      // [2] cycle_done, [26:3] average_ppm
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wr_data
);

    localparam logic [2:0] T_IDLE   = 3'd0;
    localparam logic [2:0] T_CONV   = 3'd1;   // waiting on ppm conversion
    localparam logic [2:0] T_AVG_GO = 3'd2;   // launch average divide
    localparam logic [2:0] T_AVG    = 3'd3;
    localparam logic [2:0] T_OUT    = 3'd4;   // hand result to output register

    // configuration
    logic [19:0] heat_reg;
    logic [19:0] window_reg;
    logic [15:0] interval_reg;
    logic [11:0] floor_reg;
    logic [11:0] fs_reg;
    logic [15:0] lr_reg;

    // cycle state
    logic [2:0]  state_reg, state_next;
    logic        phase_reg, phase_next;
    logic [19:0] pt_reg, pt_next;
    logic [15:0] ss_reg, ss_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] sum_reg, sum_next;
    logic [23:0] held_reg, held_next;
    logic        taken_reg, taken_next;
    logic        done_reg, done_next;
    logic        end_reg, end_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [31:0] m_tdata_reg, m_tdata_next;

    logic [15:0] ss_inc;
    logic [19:0] pt_inc;
    logic        take;
    logic        win_end;
    logic        accept;

    gshc_pkg::calc_cmd_t calc_cmd;
    gshc_pkg::calc_rsp_t calc_rsp;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // saturating tick counters
    assign ss_inc  = (ss_reg == 16'hFFFF) ? ss_reg : ss_reg + 16'd1;
    assign pt_inc  = (pt_reg == 20'hFFFFF) ? pt_reg : pt_reg + 20'd1;
    assign take    = (ss_inc >= interval_reg) && (cnt_reg < 8'(MAX_COUNT));
    assign win_end = (pt_inc >= window_reg);

    assign calc_cmd.start = (accept && phase_reg && take)
                          || (state_reg == T_AVG_GO && cnt_reg != 8'd0);
    assign calc_cmd.avg   = (state_reg == T_AVG_GO);

    gshc_calc u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (calc_cmd),
        .adc        (s_tdata[11:0]),
        .adc_floor  (floor_reg),
        .full_scale (fs_reg),
        .load_ratio (lr_reg),
        .sum        (sum_reg),
        .count      (cnt_reg),
        .rsp        (calc_rsp)
    );

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pt_next       = pt_reg;
        ss_next       = ss_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        held_next     = held_reg;
        taken_next    = taken_reg;
        done_next     = done_reg;
        end_next      = end_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    taken_next = 1'b0;
                    done_next  = 1'b0;
                    end_next   = 1'b0;
                    if (!phase_reg) begin
                        // heating: no sample on the switch tick
                        ss_next = ss_inc;
                        if (pt_inc >= heat_reg) begin
                            phase_next = 1'b1;
                            pt_next    = '0;
                        end else begin
                            pt_next = pt_inc;
                        end
                        state_next = T_OUT;
                    end else begin
                        ss_next    = take ? 16'd0 : ss_inc;
                        pt_next    = win_end ? 20'd0 : pt_inc;
                        end_next   = win_end;
                        taken_next = take;
                        if (take) begin
                            state_next = T_CONV;
                        end else if (win_end) begin
                            state_next = T_AVG_GO;
                        end else begin
                            state_next = T_OUT;
                        end
                    end
                end
            end
            T_CONV: begin
                if (calc_rsp.done) begin
                    sum_next   = sum_reg + {8'd0, calc_rsp.value};
                    cnt_next   = cnt_reg + 8'd1;
                    state_next = end_reg ? T_AVG_GO : T_OUT;
                end
            end
            T_AVG_GO: begin
                if (cnt_reg == 8'd0) begin
                    // empty window averages to zero
                    held_next  = '0;
                    sum_next   = '0;
                    phase_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = T_OUT;
                end else begin
                    state_next = T_AVG;
                end
            end
            T_AVG: begin
                if (calc_rsp.done) begin
                    held_next  = calc_rsp.value;
                    sum_next   = '0;
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = T_OUT;
                end
            end
            T_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'd0, held_reg, done_reg, taken_reg, phase_reg};
                    state_next    = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            phase_reg    <= 1'b0;
            pt_reg       <= '0;
            ss_reg       <= 16'hFFFF;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            held_reg     <= '0;
            taken_reg    <= 1'b0;
            done_reg     <= 1'b0;
            end_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            pt_reg       <= pt_next;
            ss_reg       <= ss_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            held_reg     <= held_next;
            taken_reg    <= taken_next;
            done_reg     <= done_next;
            end_reg      <= end_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_reg     <= gshc_pkg::HEAT_TICKS_RST;
            window_reg   <= gshc_pkg::WINDOW_TICKS_RST;
            interval_reg <= gshc_pkg::SAMPLE_INTERVAL_RST;
            floor_reg    <= gshc_pkg::ADC_FLOOR_RST;
            fs_reg       <= gshc_pkg::FULL_SCALE_RST;
            lr_reg       <= gshc_pkg::LOAD_RATIO_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                gshc_pkg::REG_HEAT_TICKS:      heat_reg     <= cfg_wr_data;
                gshc_pkg::REG_WINDOW_TICKS:    window_reg   <= cfg_wr_data;
                gshc_pkg::REG_SAMPLE_INTERVAL: interval_reg <= cfg_wr_data[15:0];
                gshc_pkg::REG_ADC_FLOOR:       floor_reg    <= cfg_wr_data[11:0];
                gshc_pkg::REG_FULL_SCALE:      fs_reg       <= cfg_wr_data[11:0];
                gshc_pkg::REG_LOAD_RATIO:      lr_reg       <= cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/core/gshc_calc.sv */
`timescale 1ns / 1ps
// Serial arithmetic: shift-add multiplier, restoring divider, restoring root.
module gshc_calc (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gshc_pkg::calc_cmd_t   cmd,
    input  logic [11:0]           adc,
    input  logic [11:0]           adc_floor,
    input  logic [11:0]           full_scale,
    input  logic [15:0]           load_ratio,
    input  logic [31:0]           sum,
    input  logic [7:0]            count,
    output gshc_pkg::calc_rsp_t   rsp
);

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_MUL  = 3'd1;
    localparam logic [2:0] C_DIV  = 3'd2;
    localparam logic [2:0] C_SQRT = 3'd3;
    localparam logic [2:0] C_DONE = 3'd4;

    localparam logic [6:0] MUL_STEPS  = 7'd32;
    localparam logic [6:0] DIV_STEPS  = 7'd82;
    localparam logic [6:0] SQRT_STEPS = 7'd24;

    logic [2:0]  state_reg, state_next;
    logic [87:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [87:0] prod_reg, prod_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [2:0]  step_reg, step_next;
    logic [27:0] d_reg, d_next;
    logic [83:0] dv_reg, dv_next;
    logic [81:0] num_reg, num_next;
    logic [83:0] rem_reg, rem_next;
    logic [47:0] q_reg, q_next;
    logic        big_reg, big_next;
    logic [25:0] srem_reg, srem_next;
    logic [23:0] root_reg, root_next;
    logic [11:0] adc_reg, adc_next;
    logic        avg_reg, avg_next;
    logic [23:0] res_reg, res_next;

    logic [87:0] prod_sum;
    logic [84:0] r_div, div_diff;
    logic        div_ge;
    logic [47:0] q_shift;
    logic [25:0] r_sq, trial;
    logic        sq_ge;

    assign prod_sum = prod_reg + (mplier_reg[0] ? mcand_reg : 88'd0);
    assign r_div    = {rem_reg, num_reg[81]};
    assign div_ge   = r_div >= {1'b0, dv_reg};
    assign div_diff = r_div - {1'b0, dv_reg};
    assign q_shift  = {q_reg[46:0], div_ge};
    assign r_sq     = {srem_reg[23:0], q_reg[47:46]};
    assign trial    = {root_reg, 2'b01};
    assign sq_ge    = r_sq >= trial;

    assign rsp.done  = (state_reg == C_DONE);
    assign rsp.value = res_reg;

    always_comb begin
        state_next  = state_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        cnt_next    = cnt_reg;
        step_next   = step_reg;
        d_next      = d_reg;
        dv_next     = dv_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        q_next      = q_reg;
        big_next    = big_reg;
        srem_next   = srem_reg;
        root_next   = root_reg;
        adc_next    = adc_reg;
        avg_next    = avg_reg;
        res_next    = res_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (cmd.start) begin
                    avg_next = cmd.avg;
                    adc_next = adc;
                    if (cmd.avg) begin
                        num_next   = {50'd0, sum};
                        dv_next    = {76'd0, count};
                        rem_next   = '0;
                        q_next     = '0;
                        big_next   = 1'b0;
                        cnt_next   = DIV_STEPS;
                        state_next = C_DIV;
                    end else if (adc <= adc_floor) begin
                        res_next   = '0;
                        state_next = C_DONE;
                    end else if (adc >= full_scale || load_ratio == 16'd0) begin
                        res_next   = gshc_pkg::PPM_MAX;
                        state_next = C_DONE;
                    end else begin
                        // D = (full_scale - adc) * load_ratio
                        mcand_next  = {76'd0, full_scale - adc};
                        mplier_next = {16'd0, load_ratio};
                        prod_next   = '0;
                        step_next   = 3'd0;
                        cnt_next    = MUL_STEPS;
                        state_next  = C_MUL;
                    end
                end
            end
            C_MUL: begin
                prod_next   = prod_sum;
                mcand_next  = {mcand_reg[86:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
                cnt_next    = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    prod_next = '0;
                    cnt_next  = MUL_STEPS;
                    step_next = step_reg + 3'd1;
                    case (step_reg)
                        3'd0: begin
                            d_next      = prod_sum[27:0];
                            mcand_next  = prod_sum;
                            mplier_next = {4'd0, prod_sum[27:0]};
                        end
                        3'd1: begin
                            mcand_next  = prod_sum;
                            mplier_next = {4'd0, d_reg};
                        end
                        3'd2: begin
                            dv_next     = prod_sum[83:0];
                            mcand_next  = {76'd0, adc_reg};
                            mplier_next = {20'd0, adc_reg};
                        end
                        3'd3: begin
                            mcand_next  = prod_sum;
                            mplier_next = {20'd0, adc_reg};
                        end
                        3'd4: begin
                            mcand_next  = prod_sum;
                            mplier_next = gshc_pkg::KSQ;
                        end
                        default: begin
                            // numerator KSQ * adc^3 * 2^14 over D^3
                            num_next   = {prod_sum[67:0], 14'd0};
                            rem_next   = '0;
                            q_next     = '0;
                            big_next   = 1'b0;
                            cnt_next   = DIV_STEPS;
                            state_next = C_DIV;
                        end
                    endcase
                end
            end
            C_DIV: begin
                rem_next = div_ge ? div_diff[83:0] : r_div[83:0];
                num_next = {num_reg[80:0], 1'b0};
                q_next   = q_shift;
                big_next = big_reg | q_reg[47];
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    if (avg_reg) begin
                        res_next   = q_shift[23:0];
                        state_next = C_DONE;
                    end else if (big_reg | q_reg[47]) begin
                        res_next   = gshc_pkg::PPM_MAX;
                        state_next = C_DONE;
                    end else begin
                        srem_next  = '0;
                        root_next  = '0;
                        cnt_next   = SQRT_STEPS;
                        state_next = C_SQRT;
                    end
                end
            end
            C_SQRT: begin
                srem_next = sq_ge ? (r_sq - trial) : r_sq;
                root_next = {root_reg[22:0], sq_ge};
                q_next    = {q_reg[45:0], 2'b00};
                cnt_next  = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    res_next   = {root_reg[22:0], sq_ge};
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
        cnt_reg    <= cnt_next;
        step_reg   <= step_next;
        d_reg      <= d_next;
        dv_reg     <= dv_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        big_reg    <= big_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        adc_reg    <= adc_next;
        avg_reg    <= avg_next;
        res_reg    <= res_next;
    end

endmodule

/* tb/gshc_checker.sv */
`timescale 1ns / 1ps
module gshc_checker
    import gshc_pkg::*;
#(
    parameter int MAX_COUNT = MAX_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [19:0] cfg_wr_data,
    output int          fail_count,
    output int          result_count,
    output int          pending,
    output int          samples_seen,
    output int          cycles_seen
);

    // packed from the top bit down: average_ppm sits in [26:3], heater_on in [0]
    typedef struct packed {
        logic [23:0] average_ppm;
        logic        cycle_done;
        logic        sample_taken;
        logic        heater_on;
    } tick_result_t;

    logic [19:0] heat_ticks, window_ticks;
    logic [15:0] sample_interval, load_ratio;
    logic [11:0] adc_floor, full_scale;

    logic        sampling;
    logic [19:0] phase_ticks;
    logic [15:0] since_sample;
    logic [7:0]  sample_count;
    logic [31:0] ppm_sum;
    logic [23:0] held_average;

    tick_result_t expected_ticks[$];

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // largest y < 2^24 with y^2 * 1024 * D^3 <= KSQ * A^3
    function automatic logic [23:0] code_to_ppm(input logic [11:0] adc);
        logic [191:0] rhs, dcube, lhs;
        logic [31:0]  a, d;
        logic [23:0]  y, t;
        if (adc <= adc_floor) return 24'd0;
        if (adc >= full_scale || load_ratio == 0) return PPM_MAX;
        a = {12'd0, adc, 8'd0};
        d = 32'(full_scale - adc) * 32'(load_ratio);
        rhs = 192'(KSQ);
        rhs = rhs * a;
        rhs = rhs * a;
        rhs = rhs * a;
        dcube = 192'd1024;
        dcube = dcube * d;
        dcube = dcube * d;
        dcube = dcube * d;
        y = 24'd0;
        for (int b = 23; b >= 0; b--) begin
            t = y | (24'd1 << b);
            lhs = dcube * t;
            lhs = lhs * t;
            if (lhs <= rhs) y = t;
        end
        return y;
    endfunction

    function automatic tick_result_t predict_tick(input logic [11:0] adc);
        tick_result_t r;
        r = '0;
        if (since_sample != 16'hFFFF) since_sample++;
        if (phase_ticks != 20'hFFFFF) phase_ticks++;
        if (!sampling) begin
            if (phase_ticks >= heat_ticks) begin
                sampling = 1'b1;
                phase_ticks = '0;
            end
        end else begin
            if (since_sample >= sample_interval && sample_count < MAX_COUNT) begin
                since_sample = '0;
                ppm_sum += 32'(code_to_ppm(adc));
                sample_count++;
                r.sample_taken = 1'b1;
            end
            if (phase_ticks >= window_ticks) begin
                held_average = (sample_count != 0) ? 24'(ppm_sum / 32'(sample_count)) : 24'd0;
                sample_count = '0;
                ppm_sum = '0;
                sampling = 1'b0;
                phase_ticks = '0;
                r.cycle_done = 1'b1;
            end
        end
        r.heater_on = sampling;
        r.average_ppm = held_average;
        return r;
    endfunction

    always @(posedge aclk) begin
        tick_result_t got, want;
        if (!aresetn) begin
            heat_ticks = HEAT_TICKS_RST;
            window_ticks = WINDOW_TICKS_RST;
            sample_interval = SAMPLE_INTERVAL_RST;
            adc_floor = ADC_FLOOR_RST;
            full_scale = FULL_SCALE_RST;
            load_ratio = LOAD_RATIO_RST;
            sampling = 1'b0;
            phase_ticks = '0;
            since_sample = 16'hFFFF;
            sample_count = '0;
            ppm_sum = '0;
            held_average = '0;
            expected_ticks.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_HEAT_TICKS:      heat_ticks = cfg_wr_data;
                    REG_WINDOW_TICKS:    window_ticks = cfg_wr_data;
                    REG_SAMPLE_INTERVAL: sample_interval = cfg_wr_data[15:0];
                    REG_ADC_FLOOR:       adc_floor = cfg_wr_data[11:0];
                    REG_FULL_SCALE:      full_scale = cfg_wr_data[11:0];
                    REG_LOAD_RATIO:      load_ratio = cfg_wr_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) expected_ticks.push_back(predict_tick(s_tdata[11:0]));
            if (m_tvalid && m_tready) begin
                got = tick_result_t'(m_tdata[26:0]);
                result_count++;
                if (expected_ticks.size() == 0) begin
                    report("unexpected result", m_tdata, 32'd0);
                end else begin
                    want = expected_ticks.pop_front();
                    if (want.sample_taken) samples_seen++;
                    if (want.cycle_done) cycles_seen++;
                    if (got.heater_on != want.heater_on)
                        report("heater_on", 32'(got.heater_on), 32'(want.heater_on));
                    if (got.sample_taken != want.sample_taken)
                        report("sample_taken", 32'(got.sample_taken), 32'(want.sample_taken));
                    if (got.cycle_done != want.cycle_done)
                        report("cycle_done", 32'(got.cycle_done), 32'(want.cycle_done));
                    if (got.average_ppm != want.average_ppm)
                        report("average_ppm", 32'(got.average_ppm), 32'(want.average_ppm));
                    if (m_tdata[31:27] != 0)
                        report("pad bits", 32'(m_tdata[31:27]), 32'd0);
                end
            end
        end
        pending = expected_ticks.size();
    end

    initial begin
        fail_count = 0;
        result_count = 0;
        pending = 0;
        samples_seen = 0;
        cycles_seen = 0;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
    import gshc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 400;   // longer than one sample plus window close

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // [11:0] adc_code
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // [0] heater_on, [1] sample_taken, [2] cycle_done,
                                // [26:3] average_ppm
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [19:0] cfg_wr_data;

    int fail_count, result_count, pending, samples_seen, cycles_seen;
    int ticks_sent;
    int send_idle_pct, recv_stall_pct;
    bit hold_request;           // asks the receiver for one long hold-off
    int idle_cycles;

    // current configuration mirror, used to aim the codes
    logic [11:0] cur_floor, cur_fs;

    gas_sensor_heat_sample_cycle u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    gshc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data),
        .fail_count(fail_count), .result_count(result_count), .pending(pending),
        .samples_seen(samples_seen), .cycles_seen(cycles_seen)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // watchdog: cycles without any request moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                for (int i = 0; i < 600; i++) begin
                    m_tready <= 1'b0;
                    @(negedge aclk);
                end
            end
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // one tick request; enters and leaves at a falling edge
    task automatic send_tick(input logic [11:0] adc);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, adc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_count != ticks_sent || pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_regs(input logic [19:0] heat, input logic [19:0] win,
                            input logic [15:0] intv, input logic [11:0] flr,
                            input logic [11:0] fs, input logic [15:0] lr);
        write_reg(REG_HEAT_TICKS, heat);
        write_reg(REG_WINDOW_TICKS, win);
        write_reg(REG_SAMPLE_INTERVAL, {4'd0, intv});
        write_reg(REG_ADC_FLOOR, {8'd0, flr});
        write_reg(REG_FULL_SCALE, {8'd0, fs});
        write_reg(REG_LOAD_RATIO, {4'd0, lr});
        cur_floor = flr;
        cur_fs = fs;
    endtask

    // codes aimed at the floor and full-scale edges, plus uniform noise
    function automatic logic [11:0] pick_code();
        int v;
        case ($urandom_range(5))
            0: v = $urandom_range(4095);
            1: v = int'(cur_floor) + $urandom_range(4) - 2;
            2: v = int'(cur_fs) + $urandom_range(6) - 3;
            3: v = ($urandom_range(1) != 0) ? 0 : 4095;
            default: v = $urandom_range(int'(cur_fs), int'(cur_floor));
        endcase
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return 12'(v);
    endfunction

    task automatic random_ticks(input int n);
        for (int i = 0; i < n; i++) send_tick(pick_code());
    endtask

    logic [11:0] directed_codes[20] = '{12'd0, 12'd124, 12'd125, 12'd4095, 12'd4094,
        12'd1, 12'd2048, 12'd4000, 12'd3000, 12'd200, 12'd125, 12'd4095, 12'd0,
        12'd1024, 12'd3500, 12'd4093, 12'd126, 12'd2730, 12'd1365, 12'd3900};

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        hold_request = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        ticks_sent = 0;
        idle_cycles = 0;
        cur_floor = ADC_FLOOR_RST;
        cur_fs = FULL_SCALE_RST;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: long heating, nothing sampled
        for (int i = 0; i < 5; i++) send_tick(directed_codes[i]);
        drain();

        // short cycle, a sample on every sampling tick: floor, full scale, edges
        set_regs(20'd1, 20'd20, 16'd1, 12'd124, 12'd4095, 16'd256);
        foreach (directed_codes[i]) send_tick(directed_codes[i]);
        drain();

        for (int p = 0; p < 9; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (p)
                // long window, sample every tick: hits the sample cap
                0: set_regs(20'd2, 20'd200, 16'd1, 12'd0, 12'd4095, 16'd1);
                // zero counts, zero load ratio
                1: set_regs(20'd0, 20'd0, 16'd0, 12'd0, 12'd4095, 16'd0);
                // longest heat; stays heating
                2: set_regs(20'hFFFFF, 20'd5, 16'd1, 12'd4095, 12'd1, 16'd65535);
                // longest interval, tiny full scale, largest ratio
                3: set_regs(20'd3, 20'd40, 16'hFFFF, 12'd100, 12'd1, 16'hFFFF);
                // longest window
                4: set_regs(20'd1, 20'hFFFFF, 16'd2, 12'd50, 12'd4095, 16'd256);
                default: set_regs(20'($urandom_range(1, 30)), 20'($urandom_range(1, 80)),
                                  16'($urandom_range(1, 6)), 12'($urandom_range(600)),
                                  12'($urandom_range(2000, 4095)),
                                  16'(($urandom_range(1) != 0) ? $urandom_range(1, 1024)
                                                               : $urandom_range(1, 65535)));
            endcase
            if (p == 5) begin
                // receiver blocks long while ticks keep coming
                hold_request = 1'b1;
                random_ticks(80);
                random_ticks(70);
            end else if (p == 6) begin
                // sender waits for every result mid-phase
                random_ticks(70);
                s_tvalid <= 1'b0;
                while (result_count != ticks_sent) @(negedge aclk);
                random_ticks(80);
            end else if (p == 2) begin
                random_ticks(40);
            end else begin
                random_ticks(150);
            end
            drain();
        end

        $display("ran %0d ticks, %0d results, %0d conversions, %0d averages",
                 ticks_sent, result_count, samples_seen, cycles_seen);
        $display("covered floor/full-scale edges, zero and max registers, sample cap, stalls");
        if (pending != 0) $display("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
